FILE: rtl/bsc_pkg.sv
// Shared types and codes for the banker's safety check unit.
`default_nettype none

package bsc_pkg;

  // Item modes
  typedef enum logic [1:0] {
    MODE_LOAD_ENTRY = 2'd0,
    MODE_LOAD_FREE  = 2'd1,
    MODE_RUN        = 2'd2
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_REL_RD,
    ST_REL_WR,
    ST_FINISH,
    ST_FINAL
  } state_e;

  // Configuration register indexes
  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  localparam int CountRegWidth = 5;
  localparam int ApbAddrWidth  = 3;
  localparam int ApbDataWidth  = 32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  process_index;
    logic [3:0]  resource_index;
    logic [15:0] allocated;
    logic [15:0] maximum;
    logic [15:0] available;
  } in_item_t;

  typedef struct packed {
    logic [3:0] finished_process;
    logic       entry_valid;
    logic       safe;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/bsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/bsc_cfg.sv
// APB register file for the process and resource counts.
`default_nettype none

module bsc_cfg #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16,
  localparam int PCW = $clog2(MAX_PROCESSES + 1),
  localparam int RCW = $clog2(MAX_RESOURCES + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bsc_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [bsc_pkg::ApbDataWidth-1:0]  pwdata,
  output logic      [bsc_pkg::ApbDataWidth-1:0]  prdata,
  output logic                                   pready,
  output logic      [PCW-1:0]                    np_o,
  output logic      [RCW-1:0]                    nr_o
);

  logic [bsc_pkg::CountRegWidth-1:0] pcount_q, pcount_d;
  logic [bsc_pkg::CountRegWidth-1:0] rcount_q, rcount_d;
  logic                              wr_en;
  logic                              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Decode the write transaction
  always_comb begin
    pcount_d = pcount_q;
    rcount_d = rcount_q;
    if (wr_en) begin
      case (reg_sel)
        bsc_pkg::REG_PROCESS_COUNT:  pcount_d = pwdata[bsc_pkg::CountRegWidth-1:0];
        bsc_pkg::REG_RESOURCE_COUNT: rcount_d = pwdata[bsc_pkg::CountRegWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= bsc_pkg::CountRegWidth'(16);
      rcount_q <= bsc_pkg::CountRegWidth'(16);
    end else begin
      pcount_q <= pcount_d;
      rcount_q <= rcount_d;
    end
  end

  // Return the raw register value
  always_comb begin
    case (reg_sel)
      bsc_pkg::REG_PROCESS_COUNT:  prdata = bsc_pkg::ApbDataWidth'(pcount_q);
      bsc_pkg::REG_RESOURCE_COUNT: prdata = bsc_pkg::ApbDataWidth'(rcount_q);
      default:                     prdata = '0;
    endcase
  end

  // Clamp counts: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (pcount_q == '0) begin
      np_o = PCW'(1);
    end else if (32'(pcount_q) > MAX_PROCESSES) begin
      np_o = PCW'(MAX_PROCESSES);
    end else begin
      np_o = PCW'(pcount_q);
    end
    if (rcount_q == '0) begin
      nr_o = RCW'(1);
    end else if (32'(rcount_q) > MAX_RESOURCES) begin
      nr_o = RCW'(MAX_RESOURCES);
    end else begin
      nr_o = RCW'(rcount_q);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bsc_arith.sv
// Shared compare and saturating add unit for need checks and releases.
`default_nettype none

module bsc_arith #(
  parameter int COUNT_WIDTH = 16,
  localparam int FW         = COUNT_WIDTH + 5
) (
  input  wire logic [COUNT_WIDTH-1:0] need_i,
  input  wire logic [COUNT_WIDTH-1:0] alloc_i,
  input  wire logic [FW-1:0]          free_i,
  output logic                        need_gt_o,
  output logic      [FW-1:0]          sum_o
);

  logic [FW:0] sum_full;

  // Compare need against the free count
  assign need_gt_o = FW'(need_i) > free_i;

  // Add the released allocation, saturate at the top of the free width
  assign sum_full = {1'b0, free_i} + (FW + 1)'(alloc_i);
  assign sum_o    = sum_full[FW] ? {FW{1'b1}} : sum_full[FW-1:0];

endmodule

`default_nettype wire

FILE: rtl/bsc_ctrl.sv
// Sequencer, tables and result register of the safety check.
`default_nettype none

module bsc_ctrl #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16,
  parameter int COUNT_WIDTH   = 16,
  localparam int PCW = $clog2(MAX_PROCESSES + 1),
  localparam int RCW = $clog2(MAX_RESOURCES + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [PCW-1:0]       np_i,
  input  wire logic [RCW-1:0]       nr_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bsc_pkg::in_item_t    in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output bsc_pkg::out_item_t        out_item_o
);

  localparam int FW    = COUNT_WIDTH + 5;
  localparam int PIW   = $clog2(MAX_PROCESSES);
  localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int TDEP  = MAX_PROCESSES * MAX_RESOURCES;
  localparam int TAW   = $clog2(TDEP);

  bsc_pkg::state_e    state_q, state_d;
  logic [PCW-1:0]     p_q, p_d;
  logic [RIW-1:0]     r_q, r_d;
  logic [PCW-1:0]     found_q, found_d;
  logic               progress_q, progress_d;
  logic               pend_valid_q, pend_valid_d;
  logic [PIW-1:0]     pend_p_q, pend_p_d;
  logic [MAX_PROCESSES-1:0] done_q, done_d;
  logic               out_valid_q, out_valid_d;
  bsc_pkg::out_item_t out_item_q, out_item_d;

  logic [PIW-1:0]         pidx;
  logic                   r_last;
  logic                   slot_free;
  logic                   ld_in_range;
  logic                   free_in_range;
  logic [COUNT_WIDTH-1:0] ld_alloc;
  logic [COUNT_WIDTH-1:0] ld_max;
  logic [COUNT_WIDTH-1:0] ld_need;
  logic [TAW-1:0]         ld_addr;
  logic [TAW-1:0]         run_addr;
  logic                   tab_we;
  logic                   free_we;
  logic [RIW-1:0]         free_waddr;
  logic [FW-1:0]          free_wdata;
  logic [COUNT_WIDTH-1:0] need_rdata;
  logic [COUNT_WIDTH-1:0] alloc_rdata;
  logic [FW-1:0]          free_rdata;
  logic                   need_gt;
  logic [FW-1:0]          rel_sum;

  assign pidx      = p_q[PIW-1:0];
  assign r_last    = (RCW'(r_q) + RCW'(1)) == nr_i;
  assign slot_free = !out_valid_q || out_ready_i;

  // Load entry decode: need is maximum minus allocated, clamped at zero
  assign ld_alloc      = COUNT_WIDTH'(in_item_i.allocated);
  assign ld_max        = COUNT_WIDTH'(in_item_i.maximum);
  assign ld_need       = (ld_max > ld_alloc) ? (ld_max - ld_alloc) : '0;
  assign ld_in_range   = (32'(in_item_i.process_index) < MAX_PROCESSES) &&
                         (32'(in_item_i.resource_index) < MAX_RESOURCES);
  assign free_in_range = 32'(in_item_i.resource_index) < MAX_RESOURCES;
  assign ld_addr       = TAW'(32'(in_item_i.process_index) * MAX_RESOURCES +
                              32'(in_item_i.resource_index));
  assign run_addr      = TAW'(pidx) * TAW'(MAX_RESOURCES) + TAW'(r_q);

  // Tables
  bsc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TDEP)) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (ld_addr),
    .wdata_i (ld_alloc),
    .raddr_i (run_addr),
    .rdata_o (alloc_rdata)
  );

  bsc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TDEP)) u_need_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (ld_addr),
    .wdata_i (ld_need),
    .raddr_i (run_addr),
    .rdata_o (need_rdata)
  );

  bsc_ram #(.WIDTH(FW), .DEPTH(MAX_RESOURCES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (r_q),
    .rdata_o (free_rdata)
  );

  bsc_arith #(.COUNT_WIDTH(COUNT_WIDTH)) u_arith (
    .need_i    (need_rdata),
    .alloc_i   (alloc_rdata),
    .free_i    (free_rdata),
    .need_gt_o (need_gt),
    .sum_o     (rel_sum)
  );

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    r_d          = r_q;
    found_d      = found_q;
    progress_d   = progress_q;
    pend_valid_d = pend_valid_q;
    pend_p_d     = pend_p_q;
    done_d       = done_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_item_d   = out_item_q;
    in_ready_o   = 1'b0;
    tab_we       = 1'b0;
    free_we      = 1'b0;
    free_waddr   = r_q;
    free_wdata   = rel_sum;

    case (state_q)
      bsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (bsc_pkg::mode_e'(in_item_i.mode))
            bsc_pkg::MODE_LOAD_ENTRY: begin
              tab_we = ld_in_range;
            end
            bsc_pkg::MODE_LOAD_FREE: begin
              free_we    = free_in_range;
              free_waddr = RIW'(in_item_i.resource_index);
              free_wdata = FW'(COUNT_WIDTH'(in_item_i.available));
            end
            bsc_pkg::MODE_RUN: begin
              done_d       = '0;
              p_d          = '0;
              found_d      = '0;
              progress_d   = 1'b0;
              pend_valid_d = 1'b0;
              state_d      = bsc_pkg::ST_NEXT;
            end
            default: ;
          endcase
        end
      end

      // Pick the next candidate or close the pass
      bsc_pkg::ST_NEXT: begin
        if (p_q == np_i) begin
          if (progress_q) begin
            p_d        = '0;
            progress_d = 1'b0;
          end else begin
            state_d = bsc_pkg::ST_FINAL;
          end
        end else if (done_q[pidx]) begin
          p_d = p_q + PCW'(1);
        end else begin
          r_d     = '0;
          state_d = bsc_pkg::ST_CHK_RD;
        end
      end

      bsc_pkg::ST_CHK_RD: begin
        state_d = bsc_pkg::ST_CHK_CMP;
      end

      // Drop the candidate on the first need above the free count
      bsc_pkg::ST_CHK_CMP: begin
        if (need_gt) begin
          p_d     = p_q + PCW'(1);
          state_d = bsc_pkg::ST_NEXT;
        end else if (r_last) begin
          r_d     = '0;
          state_d = bsc_pkg::ST_REL_RD;
        end else begin
          r_d     = r_q + RIW'(1);
          state_d = bsc_pkg::ST_CHK_RD;
        end
      end

      bsc_pkg::ST_REL_RD: begin
        state_d = bsc_pkg::ST_REL_WR;
      end

      // Return the allocation to the free counts
      bsc_pkg::ST_REL_WR: begin
        free_we = 1'b1;
        if (r_last) begin
          state_d = bsc_pkg::ST_FINISH;
        end else begin
          r_d     = r_q + RIW'(1);
          state_d = bsc_pkg::ST_REL_RD;
        end
      end

      // Push out the held entry, hold this one until the run's end is known
      bsc_pkg::ST_FINISH: begin
        if (!pend_valid_q || slot_free) begin
          if (pend_valid_q) begin
            out_valid_d                 = 1'b1;
            out_item_d.finished_process = 4'(pend_p_q);
            out_item_d.entry_valid      = 1'b1;
            out_item_d.safe             = 1'b0;
            out_item_d.last             = 1'b0;
          end
          pend_p_d     = pidx;
          pend_valid_d = 1'b1;
          done_d[pidx] = 1'b1;
          found_d      = found_q + PCW'(1);
          progress_d   = 1'b1;
          p_d          = p_q + PCW'(1);
          state_d      = bsc_pkg::ST_NEXT;
        end
      end

      // Emit the closing transaction of the run
      bsc_pkg::ST_FINAL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d.last = 1'b1;
          if (pend_valid_q) begin
            out_item_d.finished_process = 4'(pend_p_q);
            out_item_d.entry_valid      = 1'b1;
            out_item_d.safe             = (found_q == np_i);
          end else begin
            out_item_d.finished_process = '0;
            out_item_d.entry_valid      = 1'b0;
            out_item_d.safe             = 1'b0;
          end
          state_d = bsc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bsc_pkg::ST_IDLE;
      p_q          <= '0;
      r_q          <= '0;
      found_q      <= '0;
      progress_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      done_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      p_q          <= p_d;
      r_q          <= r_d;
      found_q      <= found_d;
      progress_q   <= progress_d;
      pend_valid_q <= pend_valid_d;
      done_q       <= done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_p_q   <= pend_p_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A process never finishes twice in one run
  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsc_pkg::ST_FINISH |-> !done_q[pidx])
    else $error("finished process already marked done");

  // The finished count never exceeds the process count
  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != bsc_pkg::ST_IDLE |-> found_q <= np_i)
    else $error("finished count above process count");

  // Resource index stays inside the active columns
  a_r_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsc_pkg::ST_CHK_CMP || state_q == bsc_pkg::ST_REL_WR) |->
      RCW'(r_q) < nr_i)
    else $error("resource index beyond resource count");

  // A safe verdict only rides on the last, valid entry
  a_safe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.safe |-> out_item_o.last && out_item_o.entry_valid)
    else $error("safe flag on a non-final or empty result");

  // Candidate scan starts only at resource zero on a process inside the active range
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsc_pkg::ST_NEXT && state_d == bsc_pkg::ST_CHK_RD |=>
      r_q == '0 && p_q < np_i)
    else $error("scan started outside the process range");

endmodule

`default_nettype wire

FILE: rtl/bankers_safety_check_unit.sv
// Top level of the banker's algorithm safety check unit.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | to unit   | in_valid_i / in_ready_o | in_item_i (load or run)
//  out     | from unit | out_valid_o/out_ready_i | out_item_o (safe sequence)
//  apb     | to unit   | psel/penable, pready    | process and resource counts
//
//  Loads may follow back to back. A run reads and compares once per resource
//  checked on each candidate visit, and reads and writes once per resource to
//  release each finishing process, over up to np+1 passes; the single read port
//  of each table and of the free count memory sets this.
//  Reset clears the finished flags and counts; tables hold nothing until loaded.
//  A result not taken holds in the output register and stalls the sequencer.
`default_nettype none

module bankers_safety_check_unit #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 16,
  parameter int COUNT_WIDTH   = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire bsc_pkg::in_item_t                 in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output bsc_pkg::out_item_t                     out_item_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bsc_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [bsc_pkg::ApbDataWidth-1:0]  pwdata,
  output logic      [bsc_pkg::ApbDataWidth-1:0]  prdata,
  output logic                                   pready
);

  localparam int PCW = $clog2(MAX_PROCESSES + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);

  logic [PCW-1:0] np;
  logic [RCW-1:0] nr;

  // Configuration registers
  bsc_cfg #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .np_o    (np),
    .nr_o    (nr)
  );

  // Sequencer with tables and shared arithmetic
  bsc_ctrl #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .np_i        (np),
    .nr_i        (nr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: test/bankers_safety_check_unit_tb.sv
// Self-checking testbench for the banker's safety check unit against a predictor.
`timescale 1ns / 1ps

module bankers_safety_check_unit_tb;

  localparam int MaxProcs    = 16;
  localparam int MaxRes      = 16;
  localparam int CountWidth  = 16;
  localparam int IdleLimit   = 20000;
  localparam int LongHold    = 400;
  localparam int RandomItems = 120;
  localparam int DrainCycles = 8;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [20:0] FreeMax     = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  bsc_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  bsc_pkg::out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bsc_pkg::ApbAddrWidth-1:0] paddr = '0;
  logic [bsc_pkg::ApbDataWidth-1:0] pwdata = '0;
  logic [bsc_pkg::ApbDataWidth-1:0] prdata;
  logic pready;

  // Transactions waiting for the driver, and safe-sequence entries still to come
  bsc_pkg::in_item_t item_q[$];
  bsc_pkg::out_item_t pending_seq_q[$];

  // Predictor copy of the unit's tables and count registers
  logic [15:0] alloc_tbl [MaxProcs][MaxRes];
  logic [15:0] need_tbl [MaxProcs][MaxRes];
  logic [20:0] free_tbl [MaxRes];
  logic [4:0] proc_cnt_reg = 5'd16;
  logic [4:0] res_cnt_reg = 5'd16;

  // Which entries the stimulus has loaded so far
  bit entry_set [MaxProcs][MaxRes];
  bit free_set [MaxRes];

  int items_in_flight = 0;
  int stim_items = 0;
  int err_cnt = 0;
  int long_hold_req = 0;
  int idle_cycles = 0;

  // Driver state
  int gap_left = 0;
  int burst_left = 0;

  // Receiver state
  int hold_seen = 0;
  int hold_left = 0;
  int pat = 0;
  int pat_left = 0;
  logic ready_nxt;

  bankers_safety_check_unit #(
    .MAX_PROCESSES(MaxProcs),
    .MAX_RESOURCES(MaxRes),
    .COUNT_WIDTH  (CountWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Map a raw count register onto the range the unit actually uses
  function automatic int eff_count(logic [4:0] raw, int top);
    if (raw == 5'd0) return 1;
    if (int'(raw) > top) return top;
    return int'(raw);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("ERROR at %0t ns: %s got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Clear finished flags, scan pass after pass, queue the safe sequence
  task automatic predict_safe_sequence();
    int np, nr, found, p, r, k;
    bit progress, fits;
    bit finished [MaxProcs];
    logic [3:0] order [MaxProcs];
    logic [21:0] sum;
    bsc_pkg::out_item_t res;
    np = eff_count(proc_cnt_reg, MaxProcs);
    nr = eff_count(res_cnt_reg, MaxRes);
    found = 0;
    for (p = 0; p < MaxProcs; p++) finished[p] = 1'b0;
    do begin
      progress = 1'b0;
      for (p = 0; p < np; p++) begin
        if (!finished[p]) begin
          fits = 1'b1;
          for (r = 0; r < nr; r++)
            if ({5'b0, need_tbl[p][r]} > free_tbl[r]) fits = 1'b0;
          if (fits) begin
            // Release the allocation, saturating the free count
            for (r = 0; r < nr; r++) begin
              sum = {1'b0, free_tbl[r]} + {6'b0, alloc_tbl[p][r]};
              free_tbl[r] = (sum > {1'b0, FreeMax}) ? FreeMax : sum[20:0];
            end
            finished[p] = 1'b1;
            order[found] = 4'(p);
            found++;
            progress = 1'b1;
          end
        end
      end
    end while (progress);
    if (found == 0) begin
      res = '0;
      res.last = 1'b1;
      pending_seq_q.push_back(res);
    end else begin
      for (k = 0; k < found; k++) begin
        res.finished_process = order[k];
        res.entry_valid = 1'b1;
        res.last = (k == found - 1);
        res.safe = res.last && (found == np);
        pending_seq_q.push_back(res);
      end
    end
  endtask

  // Apply one accepted transaction to the predictor
  task automatic apply_item(bsc_pkg::in_item_t it);
    case (it.mode)
      bsc_pkg::MODE_LOAD_ENTRY: begin
        alloc_tbl[it.process_index][it.resource_index] = it.allocated;
        need_tbl[it.process_index][it.resource_index] =
          (it.maximum > it.allocated) ? it.maximum - it.allocated : 16'd0;
      end
      bsc_pkg::MODE_LOAD_FREE: free_tbl[it.resource_index] = {5'b0, it.available};
      bsc_pkg::MODE_RUN: predict_safe_sequence();
      default: ;
    endcase
  endtask

  task automatic check_result(bsc_pkg::out_item_t got);
    bsc_pkg::out_item_t want;
    if (pending_seq_q.size() == 0) begin
      report_mismatch("result with nothing pending, finished_process",
                      16'(got.finished_process), 16'hffff);
      return;
    end
    want = pending_seq_q.pop_front();
    if (got.finished_process !== want.finished_process)
      report_mismatch("finished_process", 16'(got.finished_process),
                      16'(want.finished_process));
    if (got.entry_valid !== want.entry_valid)
      report_mismatch("entry_valid", 16'(got.entry_valid), 16'(want.entry_valid));
    if (got.safe !== want.safe)
      report_mismatch("safe", 16'(got.safe), 16'(want.safe));
    if (got.last !== want.last)
      report_mismatch("last", 16'(got.last), 16'(want.last));
  endtask

  // Driver: bursts of transactions with random gaps in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_item_i <= item_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switch among stall patterns, honor long hold-off requests
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_seen != long_hold_req) begin
        hold_seen = long_hold_req;
        hold_left = LongHold;
      end
      if (pat_left == 0) begin
        pat = $urandom_range(3);
        pat_left = $urandom_range(20, 200);
      end else begin
        pat_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else begin
        case (pat)
          0: ready_nxt = 1'b1;
          1: ready_nxt = ($urandom_range(1) == 0);
          2: ready_nxt = ($urandom_range(3) == 0);
          default: ready_nxt = ($urandom_range(4) != 0);
        endcase
      end
      out_ready_i <= ready_nxt;
    end
  end

  // Monitor: predict on input transactions, check output transactions, watch for hangs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_item(in_item_i);
        items_in_flight--;
      end
      if (out_valid_o && out_ready_i)
        check_result(out_item_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Setup cycle, access cycle, then release the bus
  task automatic write_reg(logic reg_idx, logic [4:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {27'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == bsc_pkg::REG_PROCESS_COUNT) proc_cnt_reg = value;
    else res_cnt_reg = value;
  endtask

  // Block until every transaction is in and every result is out, then let the unit settle
  task automatic wait_idle();
    while (items_in_flight != 0 || pending_seq_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly small counts, sometimes zero, full scale or a random value
  function automatic logic [15:0] pick_count(int top);
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(top));
    endcase
  endfunction

  function automatic bsc_pkg::in_item_t random_item();
    bsc_pkg::in_item_t it;
    it.mode = 2'($urandom_range(3));
    it.process_index = 4'($urandom_range(15));
    it.resource_index = 4'($urandom_range(15));
    it.allocated = 16'($urandom_range(65535));
    it.maximum = 16'($urandom_range(65535));
    it.available = 16'($urandom_range(65535));
    return it;
  endfunction

  task automatic push_item(bsc_pkg::in_item_t it);
    item_q.push_back(it);
    items_in_flight++;
    if (it.mode != MODE_UNUSED) stim_items++;
  endtask

  task automatic load_entry(int p, int r, logic [15:0] a, logic [15:0] m);
    bsc_pkg::in_item_t it;
    it = random_item();
    it.mode = bsc_pkg::MODE_LOAD_ENTRY;
    it.process_index = 4'(p);
    it.resource_index = 4'(r);
    it.allocated = a;
    it.maximum = m;
    push_item(it);
    entry_set[p][r] = 1'b1;
  endtask

  task automatic load_free(int r, logic [15:0] v);
    bsc_pkg::in_item_t it;
    it = random_item();
    it.mode = bsc_pkg::MODE_LOAD_FREE;
    it.resource_index = 4'(r);
    it.available = v;
    push_item(it);
    free_set[r] = 1'b1;
  endtask

  task automatic run_check();
    bsc_pkg::in_item_t it;
    it = random_item();
    it.mode = bsc_pkg::MODE_RUN;
    push_item(it);
  endtask

  // Unused mode, or a load anywhere in the tables
  task automatic noise_item();
    bsc_pkg::in_item_t it;
    case ($urandom_range(2))
      0: begin
        it = random_item();
        it.mode = MODE_UNUSED;
        push_item(it);
      end
      1: load_entry($urandom_range(MaxProcs - 1), $urandom_range(MaxRes - 1),
                    pick_count(65535), pick_count(65535));
      default: load_free($urandom_range(MaxRes - 1), pick_count(65535));
    endcase
  endtask

  // Set the counts while idle, then a few load-and-run sequences
  task automatic run_phase(logic [4:0] pc, logic [4:0] rc, int runs, bit hold);
    int np, nr, p, r, n;
    bit reload;
    wait_idle();
    write_reg(bsc_pkg::REG_PROCESS_COUNT, pc);
    write_reg(bsc_pkg::REG_RESOURCE_COUNT, rc);
    np = eff_count(pc, MaxProcs);
    nr = eff_count(rc, MaxRes);
    if (hold) long_hold_req++;
    for (n = 0; n < runs; n++) begin
      // Occasionally skip the free count reload and run on what the last run left
      reload = ($urandom_range(7) != 0);
      for (r = 0; r < nr; r++)
        if (reload || !free_set[r]) load_free(r, pick_count(6));
      for (p = 0; p < np; p++)
        for (r = 0; r < nr; r++)
          if (!entry_set[p][r] || $urandom_range(2) == 0)
            load_entry(p, r, pick_count(4), pick_count(10));
      repeat ($urandom_range(2)) noise_item();
      run_check();
    end
  endtask

  function automatic logic [4:0] pick_reg(int top);
    if ($urandom_range(3) != 0) return 5'($urandom_range(1, top));
    case ($urandom_range(4))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      default: return 5'd31;
    endcase
  endfunction

  initial begin
    logic [4:0] pc, rc;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Two processes, one resource
    write_reg(bsc_pkg::REG_PROCESS_COUNT, 5'd2);
    write_reg(bsc_pkg::REG_RESOURCE_COUNT, 5'd1);
    // Zero need lets process 1 go first and free enough for the full-scale need
    load_entry(0, 0, 16'd0, 16'hffff);
    load_entry(1, 0, 16'hffff, 16'd0);
    load_free(0, 16'd0);
    run_check();
    // Nothing can finish
    load_free(0, 16'd0);
    load_entry(1, 0, 16'd5, 16'd10);
    run_check();
    noise_item();
    // Loads outside the active counts
    load_entry(15, 15, 16'hffff, 16'hffff);
    load_free(15, 16'hffff);
    // Only one of the two finishes
    load_free(0, 16'd5);
    run_check();
    // Maximum equal to allocation leaves no need
    load_entry(0, 0, 16'd7, 16'd7);
    load_free(0, 16'd0);
    run_check();
    // Run again on the grown free count, without reload
    run_check();

    stim_items = 0;
    run_phase(5'd16, 5'd1, 3, 1'b1);
    run_phase(5'd1, 5'd16, 2, 1'b0);
    run_phase(5'd0, 5'd31, 1, 1'b0);
    run_phase(5'd31, 5'd0, 1, 1'b0);
    while (stim_items < RandomItems) begin
      pc = pick_reg(6);
      rc = pick_reg(4);
      // Keep the tables small so runs stay short
      if (eff_count(pc, MaxProcs) * eff_count(rc, MaxRes) > 32)
        rc = 5'($urandom_range(1, 2));
      run_phase(pc, rc, $urandom_range(1, 3), 1'b0);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_seq_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
